// File: rtl/bvm_pkg.sv
package bvm_pkg;

    // Averaging depth (power of two, 1..16)
    localparam int SAMPLES = 4;

    // Field widths
    localparam int SMP_W  = 12;
    localparam int REF_W  = 13;
    localparam int GAIN_W = 3;
    localparam int MV_W   = 15;
    localparam int TEN_W  = 8;
    localparam int CHG_W  = 8;

    localparam int ADC_FULL    = 4095;
    localparam int CHARGE_FULL = 200;
    localparam int TENTH_DIV   = 100;
    localparam int TENTH_MAX   = 255;

    // Accumulator and sample counter
    localparam int SUM_W  = $clog2(SAMPLES * ADC_FULL + 1);
    localparam int SCNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // Scaling product: raw * ref_mv * gain
    localparam int PROD1_W = SMP_W + REF_W;
    localparam int PROD_W  = PROD1_W + GAIN_W;
    // Charge product: (mv - empty) * 200
    localparam int CHGP_W  = MV_W + CHG_W;

    // Division of the scaling product by 4095: multiply by the rounded-up
    // reciprocal and drop MV_SHIFT bits, exact for every PROD_W-bit product
    localparam int MV_SHIFT = PROD_W + $clog2(ADC_FULL);
    localparam int MVP_W    = 2 * PROD_W + 1;
    localparam int MVQ_W    = MVP_W - MV_SHIFT;
    localparam logic [PROD_W:0] MV_RECIP =
        (PROD_W + 1)'(((64'd1 << MV_SHIFT) + 64'(ADC_FULL - 1)) / 64'(ADC_FULL));

    // Division of the reported voltage by 100, same scheme
    localparam int TEN_SHIFT = MV_W + $clog2(TENTH_DIV);
    localparam int TENP_W    = 2 * MV_W + 1;
    localparam int TENQ_W    = TENP_W - TEN_SHIFT;
    localparam logic [MV_W:0] TEN_RECIP =
        (MV_W + 1)'(((64'd1 << TEN_SHIFT) + 64'(TENTH_DIV - 1)) / 64'(TENTH_DIV));

    // Serial divider, used for the charge interpolation only
    localparam int DIV_W  = CHGP_W;
    localparam int DVS_W  = MV_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // Stream widths
    localparam int IN_TDATA_W  = ((SMP_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = SMP_W + MV_W + TEN_W + CHG_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // Reset values
    localparam logic [REF_W-1:0]  RST_REF_MV  = REF_W'(1250);
    localparam logic [GAIN_W-1:0] RST_GAIN    = GAIN_W'(4);
    localparam logic [MV_W-1:0]   RST_MIN_MV  = MV_W'(1200);
    localparam logic [MV_W-1:0]   RST_MAX_MV  = MV_W'(3600);
    localparam logic [MV_W-1:0]   RST_FULL_MV = MV_W'(3200);
    localparam logic [MV_W-1:0]   RST_EMPTY_MV = MV_W'(1800);
    localparam logic [MV_W-1:0]   RST_HELD_MV = MV_W'(3000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_REF_MV   = 3'd1,
        REG_GAIN     = 3'd2,
        REG_MIN_MV   = 3'd3,
        REG_MAX_MV   = 3'd4,
        REG_FULL_MV  = 3'd5,
        REG_EMPTY_MV = 3'd6
    } t_cfg_reg;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACC,
        CMD_ACC_LAST,
        CMD_HOLD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_MV_SCALE,
        CMD_MV_CHECK,
        CMD_TEN,
        CMD_CHG_DIV,
        CMD_CHG_DONE,
        CMD_LOAD_OUT
    } t_cmd;

    typedef struct packed {
        logic enable;
        logic last_sample;
        logic div_done;
        logic chg_clamp;
        logic out_free;
    } t_status;

endpackage

// File: rtl/bvm_div.sv
module bvm_div
    import bvm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,   // left-aligned
    input  logic [DVS_W-1:0]  i_divisor,
    input  logic [DCNT_W-1:0] i_steps,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo
);

    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    rem_sh;
    logic              fits;
    logic [DVS_W:0]    rem_nx;

    // One restoring step per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        fits   = (rem_sh >= {1'b0, r_dvs});
        rem_nx = fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= rem_nx[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding step");

endmodule

// File: rtl/bvm_datapath.sv
module bvm_datapath
    import bvm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [SMP_W-1:0]       i_sample,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser
);

    // Configuration
    logic              r_enable;
    logic [REF_W-1:0]  r_ref_mv;
    logic [GAIN_W-1:0] r_gain;
    logic [MV_W-1:0]   r_min_mv;
    logic [MV_W-1:0]   r_max_mv;
    logic [MV_W-1:0]   r_full_mv;
    logic [MV_W-1:0]   r_empty_mv;

    // Measurement state
    logic [SUM_W-1:0]  r_sum;
    logic [SCNT_W-1:0] r_count;
    logic [MV_W-1:0]   r_held_mv;
    logic [SMP_W-1:0]  r_last_raw;

    // Working registers
    logic [PROD_W-1:0] r_prod;
    logic [MVQ_W-1:0]  r_mv_q;
    logic [MV_W-1:0]   r_rep_mv;
    logic              r_rep_valid;
    logic [TEN_W-1:0]  r_tenths;
    logic [CHG_W-1:0]  r_charge;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    logic [SUM_W-1:0]   sum_add;
    logic [SUM_W-1:0]   avg;
    logic [PROD1_W-1:0] prod1;
    logic [PROD_W-1:0]  prod2;
    logic [MVP_W-1:0]   mv_scaled;
    logic [TENP_W-1:0]  ten_scaled;
    logic [TENQ_W-1:0]  ten_q;
    logic [MV_W-1:0]    chg_diff;
    logic [CHGP_W-1:0]  chg_prod;
    logic               ge_full;
    logic               le_empty;
    logic               in_range;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DCNT_W-1:0] div_steps;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;

    always_comb begin
        sum_add    = r_sum + SUM_W'(i_sample);
        avg        = sum_add / SUM_W'(SAMPLES);
        prod1      = PROD1_W'(r_last_raw) * PROD1_W'(r_ref_mv);
        prod2      = PROD_W'(r_prod[PROD1_W-1:0]) * PROD_W'(r_gain);
        // Reciprocal multiplications stand in for the divisions by 4095 and 100
        mv_scaled  = MVP_W'(r_prod) * MVP_W'(MV_RECIP);
        ten_scaled = TENP_W'(r_rep_mv) * TENP_W'(TEN_RECIP);
        ten_q      = ten_scaled[TENP_W-1:TEN_SHIFT];
        chg_diff   = r_rep_mv - r_empty_mv;
        chg_prod   = CHGP_W'(chg_diff) * CHGP_W'(CHARGE_FULL);
        ge_full    = (r_rep_mv >= r_full_mv);
        le_empty   = (r_rep_mv <= r_empty_mv);
        in_range   = (r_mv_q >= MVQ_W'(r_min_mv)) && (r_mv_q <= MVQ_W'(r_max_mv));
    end

    // Divider operands: charge interpolation
    always_comb begin
        div_start    = (i_cmd == CMD_CHG_DIV);
        div_dividend = r_prod[CHGP_W-1:0];
        div_divisor  = r_full_mv - r_empty_mv;
        div_steps    = DCNT_W'(CHGP_W);
    end

    bvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_ref_mv   <= RST_REF_MV;
            r_gain     <= RST_GAIN;
            r_min_mv   <= RST_MIN_MV;
            r_max_mv   <= RST_MAX_MV;
            r_full_mv  <= RST_FULL_MV;
            r_empty_mv <= RST_EMPTY_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                REG_REF_MV:   r_ref_mv   <= i_cfg_wdata[REF_W-1:0];
                REG_GAIN:     r_gain     <= i_cfg_wdata[GAIN_W-1:0];
                REG_MIN_MV:   r_min_mv   <= i_cfg_wdata[MV_W-1:0];
                REG_MAX_MV:   r_max_mv   <= i_cfg_wdata[MV_W-1:0];
                REG_FULL_MV:  r_full_mv  <= i_cfg_wdata[MV_W-1:0];
                REG_EMPTY_MV: r_empty_mv <= i_cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulator, held value and last average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_held_mv  <= RST_HELD_MV;
            r_last_raw <= '0;
        end else begin
            unique case (i_cmd)
                CMD_ACC: begin
                    r_sum   <= sum_add;
                    r_count <= r_count + SCNT_W'(1);
                end
                CMD_ACC_LAST: begin
                    r_sum      <= '0;
                    r_count    <= '0;
                    r_last_raw <= avg[SMP_W-1:0];
                end
                CMD_MV_CHECK: begin
                    if (in_range) r_held_mv <= r_mv_q[MV_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_HOLD: begin
                r_rep_mv    <= r_held_mv;
                r_rep_valid <= 1'b0;
            end
            CMD_MUL1:     r_prod <= PROD_W'(prod1);
            CMD_MUL2:     r_prod <= prod2;
            CMD_MV_SCALE: r_mv_q <= mv_scaled[MVP_W-1:MV_SHIFT];
            CMD_MV_CHECK: begin
                r_rep_mv    <= in_range ? r_mv_q[MV_W-1:0] : r_held_mv;
                r_rep_valid <= in_range;
            end
            CMD_TEN: begin
                r_tenths <= (ten_q > TENQ_W'(TENTH_MAX)) ? TEN_W'(TENTH_MAX)
                                                         : ten_q[TEN_W-1:0];
                r_charge <= ge_full ? CHG_W'(CHARGE_FULL) : '0;
                r_prod   <= PROD_W'(chg_prod);
            end
            CMD_CHG_DONE: r_charge <= div_quo[CHG_W-1:0];
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_LOAD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD_OUT) begin
            r_out_data <= OUT_TDATA_W'({r_charge, r_tenths, r_rep_mv, r_last_raw});
            r_out_user <= r_rep_valid;
        end
    end

    always_comb begin
        o_status.enable      = r_enable;
        o_status.last_sample = (r_count == SCNT_W'(SAMPLES - 1));
        o_status.div_done    = div_done;
        o_status.chg_clamp   = ge_full || le_empty;
        o_status.out_free    = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_div_free_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SCNT_W'(SAMPLES - 1))
        else $error("sample count beyond averaging depth");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_LOAD_OUT) |=> r_out_valid)
        else $error("loaded report not presented");

endmodule

// File: rtl/bvm_ctrl.sv
module bvm_ctrl
    import bvm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_CHECK,
        S_TEN,
        S_CHG_START,
        S_CHG_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    priority if (!i_status.enable) begin
                        o_cmd   = CMD_HOLD;
                        n_state = S_TEN;
                    end else if (i_status.last_sample) begin
                        o_cmd   = CMD_ACC_LAST;
                        n_state = S_MUL1;
                    end else begin
                        o_cmd   = CMD_ACC;
                    end
                end
            end
            S_MUL1: begin
                o_cmd   = CMD_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd   = CMD_MUL2;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd   = CMD_MV_SCALE;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd   = CMD_MV_CHECK;
                n_state = S_TEN;
            end
            S_TEN: begin
                o_cmd   = CMD_TEN;
                n_state = i_status.chg_clamp ? S_OUT : S_CHG_START;
            end
            S_CHG_START: begin
                o_cmd   = CMD_CHG_DIV;
                n_state = S_CHG_WAIT;
            end
            S_CHG_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_CHG_DONE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_LOAD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// File: rtl/battery_voltage_monitor_top.sv
// Supply voltage monitor.
//
// Slave stream: one 12-bit converter sample per item. Master stream: one
// report item carrying raw average, millivolts, 100 mV units and a 0..200
// half-percent charge figure; tuser flags a fresh in-range reading.
// Configuration: plain write port (enable, index, data); the user must write
// it only while the block is idle. The block itself does not enforce this.
//
// Enabled, an item that is not the last of an averaging run is accepted
// without leaving the idle state and gives no report, so such items go
// back to back. The last of a run takes the two multiplications (by the
// reference and by the gain), a reciprocal multiply for the scaling by 4095,
// the limit check, the tenths step, then the charge interpolation on the
// restoring divider (a setup step, 23 quotient bits, a result step); when
// the charge is clamped the report follows the tenths step directly.
// Disabled, an item reports the held value, entering at the tenths step.
// One item is in flight at a time; the next is taken the cycle after its report is loaded.
// Reset clears the accumulator, sets the held value to 3000 mV and loads
// the register defaults. A stalled receiver holds the report in the output
// register; the next item is still accepted and waits only at its own end.
module battery_voltage_monitor_top
    import bvm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [11:0] sample
    // Master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [11:0] raw_average, [26:12] reading_mv, [34:27] voltage_tenths,
    // [42:35] charge_half_pct
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,   // valid_res
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // Sequence one item at a time through the datapath
    bvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold configuration, accumulator, divider and output register
    bvm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (i_s_axis_tdata[SMP_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule
